@@ sv/srd_pkg.sv @@
// Shared widths, configuration indexes and transaction types for the radial dead-zone block.
`default_nettype none
package srd_pkg;
    localparam int IN_W    = 15;
    localparam int OUT_W   = 16;
    localparam int DZ_W    = 14;
    localparam int MAX_W   = 15;
    localparam int CFG_W   = 15;
    localparam int CFG_A_W = 1;
    localparam int SQ_W    = 29;
    localparam int S_W     = SQ_W + 1;
    localparam int DZ2_W   = 2 * DZ_W;
    localparam int GUARD   = 8;
    localparam int V_W     = S_W + 2 * GUARD;
    localparam int M_W     = V_W / 2;
    localparam int REM_W   = M_W + 2;
    localparam int PROD_W  = IN_W + MAX_W;
    localparam int NUM_W   = PROD_W + M_W;
    localparam int DEN_W   = M_W + MAX_W;
    localparam int QW      = OUT_W;
    localparam int DIV_W   = NUM_W + 2;

    localparam logic [CFG_A_W-1:0] CFG_DEAD_ZONE = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_MAX_LEVEL = 1'b1;

    localparam logic [DZ_W-1:0]  DZ_RESET  = DZ_W'(1638);
    localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(13107);

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic [S_W-1:0]         s;
        logic                   cfg_err;
        logic                   dead;
    } item_t;
endpackage
`default_nettype wire

@@ sv/srd_front.sv @@
// Front end: accept a sample, square the axes and classify against the configuration.
`default_nettype none
module srd_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [srd_pkg::IN_W-1:0] x_in,
    input  wire logic signed [srd_pkg::IN_W-1:0] y_in,
    input  wire logic [srd_pkg::DZ_W-1:0]        dz,
    input  wire logic [srd_pkg::MAX_W-1:0]       max_level,
    input  wire logic                            full,
    output logic                                 push,
    output srd_pkg::item_t                       item
);
    logic                              adv;
    logic signed [2*srd_pkg::IN_W-1:0] xw;
    logic signed [2*srd_pkg::IN_W-1:0] yw;
    logic signed [2*srd_pkg::IN_W-1:0] xx;
    logic signed [2*srd_pkg::IN_W-1:0] yy;
    logic [srd_pkg::DZ2_W-1:0]         dz2_reg;
    logic                              f1_vld_reg;
    logic signed [srd_pkg::IN_W-1:0]   f1_x_reg;
    logic signed [srd_pkg::IN_W-1:0]   f1_y_reg;
    logic [srd_pkg::SQ_W-1:0]          f1_xx_reg;
    logic [srd_pkg::SQ_W-1:0]          f1_yy_reg;
    logic                              f2_vld_reg;
    srd_pkg::item_t                    f2_reg;
    logic [srd_pkg::S_W-1:0]           s_next;

    assign xw   = (2*srd_pkg::IN_W)'(x_in);
    assign yw   = (2*srd_pkg::IN_W)'(y_in);
    assign xx   = xw * xw;
    assign yy   = yw * yw;
    assign adv  = !(f2_vld_reg && full);
    assign busy = !adv;
    assign push = f2_vld_reg && !full;
    assign item = f2_reg;
    assign s_next = srd_pkg::S_W'(f1_xx_reg) + srd_pkg::S_W'(f1_yy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_vld_reg <= start;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dz2_reg <= srd_pkg::DZ2_W'(dz) * srd_pkg::DZ2_W'(dz);
        if (adv)
        begin
            f1_x_reg       <= x_in;
            f1_y_reg       <= y_in;
            f1_xx_reg      <= xx[srd_pkg::SQ_W-1:0];
            f1_yy_reg      <= yy[srd_pkg::SQ_W-1:0];
            f2_reg.x       <= f1_x_reg;
            f2_reg.y       <= f1_y_reg;
            f2_reg.s       <= s_next;
            f2_reg.dead    <= s_next < srd_pkg::S_W'(dz2_reg);
            f2_reg.cfg_err <= max_level <= srd_pkg::MAX_W'(dz);
        end
    end
endmodule
`default_nettype wire

@@ sv/srd_fifo.sv @@
// Two-entry queue between the front end and the arithmetic back end.
`default_nettype none
module srd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire srd_pkg::item_t wdata,
    input  wire logic           pop,
    output srd_pkg::item_t      rdata,
    output logic                full,
    output logic                empty
);
    srd_pkg::item_t mem_reg [0:1];
    logic           wp_reg;
    logic           rp_reg;
    logic [1:0]     cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end
endmodule
`default_nettype wire

@@ sv/srd_back.sv @@
// Back end: pipelined square root, scale products, pipelined divide, round and saturate.
`default_nettype none
module srd_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_vld,
    input  wire srd_pkg::item_t             item,
    input  wire logic [srd_pkg::DZ_W-1:0]   dz,
    input  wire logic [srd_pkg::MAX_W-1:0]  max_level,
    output logic                            done,
    output logic signed [srd_pkg::OUT_W-1:0] x_out,
    output logic signed [srd_pkg::OUT_W-1:0] y_out,
    output logic                            in_dead_zone,
    output logic                            config_error
);
    typedef struct packed {
        logic signed [srd_pkg::IN_W-1:0] x;
        logic signed [srd_pkg::IN_W-1:0] y;
        logic                            cfg_err;
        logic                            dead;
    } side_t;

    typedef struct packed {
        logic [srd_pkg::REM_W-1:0] rem;
        logic [srd_pkg::M_W-1:0]   root;
        logic [srd_pkg::V_W-1:0]   val;
    } sq_t;

    typedef struct packed {
        logic [srd_pkg::DIV_W-1:0]   rem_x;
        logic [srd_pkg::DIV_W-1:0]   rem_y;
        logic [srd_pkg::QW-1:0]      q_x;
        logic [srd_pkg::QW-1:0]      q_y;
        logic [srd_pkg::DEN_W:0]     d;
        logic                        ovf_x;
        logic                        ovf_y;
        logic                        mzero;
    } dv_t;

    function automatic sq_t sq_step(input sq_t a);
        sq_t                       r;
        logic [srd_pkg::REM_W+1:0] rem2;
        logic [srd_pkg::REM_W+1:0] trial;
        rem2  = {a.rem, a.val[srd_pkg::V_W-1 -: 2]};
        trial = (srd_pkg::REM_W+2)'({a.root, 2'b01});
        r.val = {a.val[srd_pkg::V_W-3:0], 2'b00};
        if (rem2 >= trial)
        begin
            r.rem  = srd_pkg::REM_W'(rem2 - trial);
            r.root = {a.root[srd_pkg::M_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = srd_pkg::REM_W'(rem2);
            r.root = {a.root[srd_pkg::M_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic dv_t dv_step(input dv_t a, input int unsigned sh);
        dv_t                       r;
        logic [srd_pkg::DIV_W-1:0] cand;
        r    = a;
        cand = srd_pkg::DIV_W'(a.d) << sh;
        if (a.rem_x >= cand)
        begin
            r.rem_x = a.rem_x - cand;
            r.q_x   = {a.q_x[srd_pkg::QW-2:0], 1'b1};
        end
        else
        begin
            r.q_x = {a.q_x[srd_pkg::QW-2:0], 1'b0};
        end
        if (a.rem_y >= cand)
        begin
            r.rem_y = a.rem_y - cand;
            r.q_y   = {a.q_y[srd_pkg::QW-2:0], 1'b1};
        end
        else
        begin
            r.q_y = {a.q_y[srd_pkg::QW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [srd_pkg::OUT_W-1:0] sat(input logic [srd_pkg::QW-1:0] q,
                                                      input logic ovf, input logic neg);
        logic [srd_pkg::OUT_W-1:0] lim;
        lim = {1'b1, {(srd_pkg::OUT_W-1){1'b0}}};
        if (neg)
        begin
            if (ovf || srd_pkg::OUT_W'(q) > lim)
            begin
                return lim;
            end
            return srd_pkg::OUT_W'(~q + 1'b1);
        end
        if (ovf || srd_pkg::OUT_W'(q) > lim - 1'b1)
        begin
            return lim - 1'b1;
        end
        return srd_pkg::OUT_W'(q);
    endfunction

    side_t sd_reg [0:srd_pkg::M_W];
    sq_t   sq_reg [0:srd_pkg::M_W];
    side_t m1_sd_reg;
    side_t m2_sd_reg;
    side_t m3_sd_reg;
    side_t dv_sd_reg [0:srd_pkg::QW];
    dv_t   dv_reg [0:srd_pkg::QW];

    logic [srd_pkg::M_W:0]      sd_vld_reg;
    logic                       m1_vld_reg;
    logic                       m2_vld_reg;
    logic                       m3_vld_reg;
    logic [srd_pkg::QW:0]       dv_vld_reg;

    logic [srd_pkg::M_W-1:0]    m;
    logic [srd_pkg::M_W-1:0]    dzg;
    logic [srd_pkg::MAX_W-1:0]  span;
    logic [srd_pkg::IN_W-1:0]   ax;
    logic [srd_pkg::IN_W-1:0]   ay;
    logic [srd_pkg::M_W-1:0]    m1_live_reg;
    logic [srd_pkg::DEN_W-1:0]  m1_den_reg;
    logic [srd_pkg::PROD_W-1:0] m1_px_reg;
    logic [srd_pkg::PROD_W-1:0] m1_py_reg;
    logic                       m1_mz_reg;
    logic [srd_pkg::NUM_W-1:0]  m2_nx_reg;
    logic [srd_pkg::NUM_W-1:0]  m2_ny_reg;
    logic [srd_pkg::DEN_W-1:0]  m2_den_reg;
    logic                       m2_mz_reg;
    logic [srd_pkg::DIV_W-1:0]  m3_nx_reg;
    logic [srd_pkg::DIV_W-1:0]  m3_ny_reg;
    logic [srd_pkg::DEN_W:0]    m3_d_reg;
    logic                       m3_mz_reg;
    logic [srd_pkg::DIV_W-1:0]  dtop;
    logic                       zero;
    side_t                      fin;
    dv_t                        fdv;

    assign m    = sq_reg[srd_pkg::M_W].root;
    assign dzg  = srd_pkg::M_W'({dz, {srd_pkg::GUARD{1'b0}}});
    assign span = max_level - srd_pkg::MAX_W'(dz);
    assign ax   = sd_reg[srd_pkg::M_W].x[srd_pkg::IN_W-1] ? -sd_reg[srd_pkg::M_W].x
                                                          : sd_reg[srd_pkg::M_W].x;
    assign ay   = sd_reg[srd_pkg::M_W].y[srd_pkg::IN_W-1] ? -sd_reg[srd_pkg::M_W].y
                                                          : sd_reg[srd_pkg::M_W].y;
    assign dtop = srd_pkg::DIV_W'(m3_d_reg) << srd_pkg::QW;
    assign fin  = dv_sd_reg[srd_pkg::QW];
    assign fdv  = dv_reg[srd_pkg::QW];
    assign zero = fin.cfg_err || fin.dead || fdv.mzero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd_vld_reg <= '0;
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            dv_vld_reg <= '0;
            done       <= 1'b0;
        end
        else
        begin
            sd_vld_reg <= {sd_vld_reg[srd_pkg::M_W-1:0], in_vld};
            m1_vld_reg <= sd_vld_reg[srd_pkg::M_W];
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            dv_vld_reg <= {dv_vld_reg[srd_pkg::QW-1:0], m3_vld_reg};
            done       <= dv_vld_reg[srd_pkg::QW];
        end
    end

    always_ff @(posedge clk)
    begin
        sd_reg[0].x       <= item.x;
        sd_reg[0].y       <= item.y;
        sd_reg[0].cfg_err <= item.cfg_err;
        sd_reg[0].dead    <= item.dead;
        sq_reg[0].rem     <= '0;
        sq_reg[0].root    <= '0;
        sq_reg[0].val     <= {item.s, {(2*srd_pkg::GUARD){1'b0}}};
        for (int k = 0; k < srd_pkg::M_W; k++)
        begin
            sd_reg[k+1].x       <= sd_reg[k].x;
            sd_reg[k+1].y       <= sd_reg[k].y;
            sd_reg[k+1].cfg_err <= sd_reg[k].cfg_err;
            sd_reg[k+1].dead    <= sd_reg[k].dead;
            sq_reg[k+1]         <= sq_step(sq_reg[k]);
        end

        m1_sd_reg.x       <= sd_reg[srd_pkg::M_W].x;
        m1_sd_reg.y       <= sd_reg[srd_pkg::M_W].y;
        m1_sd_reg.cfg_err <= sd_reg[srd_pkg::M_W].cfg_err;
        m1_sd_reg.dead    <= sd_reg[srd_pkg::M_W].dead;
        m1_live_reg       <= (m >= dzg) ? m - dzg : '0;
        m1_den_reg        <= srd_pkg::DEN_W'(m) * srd_pkg::DEN_W'(span);
        m1_px_reg         <= srd_pkg::PROD_W'(ax) * srd_pkg::PROD_W'(max_level);
        m1_py_reg         <= srd_pkg::PROD_W'(ay) * srd_pkg::PROD_W'(max_level);
        m1_mz_reg         <= m == '0;

        m2_sd_reg.x       <= m1_sd_reg.x;
        m2_sd_reg.y       <= m1_sd_reg.y;
        m2_sd_reg.cfg_err <= m1_sd_reg.cfg_err;
        m2_sd_reg.dead    <= m1_sd_reg.dead;
        m2_nx_reg         <= srd_pkg::NUM_W'(m1_px_reg) * srd_pkg::NUM_W'(m1_live_reg);
        m2_ny_reg         <= srd_pkg::NUM_W'(m1_py_reg) * srd_pkg::NUM_W'(m1_live_reg);
        m2_den_reg        <= m1_den_reg;
        m2_mz_reg         <= m1_mz_reg;

        m3_sd_reg.x       <= m2_sd_reg.x;
        m3_sd_reg.y       <= m2_sd_reg.y;
        m3_sd_reg.cfg_err <= m2_sd_reg.cfg_err;
        m3_sd_reg.dead    <= m2_sd_reg.dead;
        m3_nx_reg         <= {1'b0, m2_nx_reg, 1'b0} + srd_pkg::DIV_W'(m2_den_reg);
        m3_ny_reg         <= {1'b0, m2_ny_reg, 1'b0} + srd_pkg::DIV_W'(m2_den_reg);
        m3_d_reg          <= {m2_den_reg, 1'b0};
        m3_mz_reg         <= m2_mz_reg;

        dv_sd_reg[0].x       <= m3_sd_reg.x;
        dv_sd_reg[0].y       <= m3_sd_reg.y;
        dv_sd_reg[0].cfg_err <= m3_sd_reg.cfg_err;
        dv_sd_reg[0].dead    <= m3_sd_reg.dead;
        dv_reg[0].rem_x      <= m3_nx_reg;
        dv_reg[0].rem_y      <= m3_ny_reg;
        dv_reg[0].q_x        <= '0;
        dv_reg[0].q_y        <= '0;
        dv_reg[0].d          <= m3_d_reg;
        dv_reg[0].ovf_x      <= m3_nx_reg >= dtop;
        dv_reg[0].ovf_y      <= m3_ny_reg >= dtop;
        dv_reg[0].mzero      <= m3_mz_reg;
        for (int k = 0; k < srd_pkg::QW; k++)
        begin
            dv_sd_reg[k+1].x       <= dv_sd_reg[k].x;
            dv_sd_reg[k+1].y       <= dv_sd_reg[k].y;
            dv_sd_reg[k+1].cfg_err <= dv_sd_reg[k].cfg_err;
            dv_sd_reg[k+1].dead    <= dv_sd_reg[k].dead;
            dv_reg[k+1]            <= dv_step(dv_reg[k], srd_pkg::QW - 1 - k);
        end

        x_out        <= zero ? '0 : sat(fdv.q_x, fdv.ovf_x, fin.x[srd_pkg::IN_W-1]);
        y_out        <= zero ? '0 : sat(fdv.q_y, fdv.ovf_y, fin.y[srd_pkg::IN_W-1]);
        config_error <= fin.cfg_err;
        in_dead_zone <= fin.dead && !fin.cfg_err;
    end
endmodule
`default_nettype wire

@@ sv/stick_radial_deadzone.sv @@
// Top level: radial scaled dead zone for one thumbstick sample per transaction.
//
// Usage:
//   Input channel: drive x_in and y_in (signed Q1.14) with start high; the
//   transaction is taken at a rising edge where busy is low. A new sample
//   may be taken every cycle.
//   Result channel: done pulses for one cycle with x_out, y_out (signed
//   Q2.14, saturated), in_dead_zone and config_error. The receiver must take
//   the result in that cycle; there is no back-pressure.
//   Configuration: cfg_we with cfg_addr 0 writes the dead zone (Q0.14),
//   cfg_addr 1 writes the maximum level (Q1.14); write only while no
//   transaction is in flight.
// Throughput: one transaction per cycle while busy is low, set by the
//   23-step square root pipeline and the 16-step divider pipeline, each a
//   stage per result bit.
// Reset: clears all valid flags and the queue, loads dead zone 1638 and
//   maximum level 13107; busy stays low while the queue drains every cycle.
`default_nettype none
module stick_radial_deadzone (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [srd_pkg::IN_W-1:0]   x_in,
    input  wire logic signed [srd_pkg::IN_W-1:0]   y_in,
    output logic                                   done,
    output logic signed [srd_pkg::OUT_W-1:0]       x_out,
    output logic signed [srd_pkg::OUT_W-1:0]       y_out,
    output logic                                   in_dead_zone,
    output logic                                   config_error,
    input  wire logic                              cfg_we,
    input  wire logic [srd_pkg::CFG_A_W-1:0]       cfg_addr,
    input  wire logic [srd_pkg::CFG_W-1:0]         cfg_wdata
);
    logic [srd_pkg::DZ_W-1:0]  dz_reg;
    logic [srd_pkg::MAX_W-1:0] max_reg;
    logic                      push;
    logic                      full;
    logic                      empty;
    srd_pkg::item_t            f_item;
    srd_pkg::item_t            q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg  <= srd_pkg::DZ_RESET;
            max_reg <= srd_pkg::MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                srd_pkg::CFG_DEAD_ZONE: dz_reg  <= cfg_wdata[srd_pkg::DZ_W-1:0];
                srd_pkg::CFG_MAX_LEVEL: max_reg <= cfg_wdata[srd_pkg::MAX_W-1:0];
                default:                dz_reg  <= dz_reg;
            endcase
        end
    end

    srd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .x_in      (x_in),
        .y_in      (y_in),
        .dz        (dz_reg),
        .max_level (max_reg),
        .full      (full),
        .push      (push),
        .item      (f_item)
    );

    srd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (f_item),
        .pop   (!empty),
        .rdata (q_item),
        .full  (full),
        .empty (empty)
    );

    srd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_vld       (!empty),
        .item         (q_item),
        .dz           (dz_reg),
        .max_level    (max_reg),
        .done         (done),
        .x_out        (x_out),
        .y_out        (y_out),
        .in_dead_zone (in_dead_zone),
        .config_error (config_error)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("front end stalled on a full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(in_dead_zone && config_error))
        else $error("dead zone and config error flagged together");
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (in_dead_zone || config_error) |-> x_out == '0 && y_out == '0)
        else $error("flagged result carries nonzero axes");
`endif
endmodule
`default_nettype wire

@@ tb/tb_stick_radial_deadzone.sv @@
// Testbench for the radial scaled dead zone: queued stimulus, clocked driver and checker.
`default_nettype none
module tb_stick_radial_deadzone;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 48;
    localparam longint LIMIT = 400000;
    localparam logic signed [srd_pkg::IN_W-1:0] IN_MIN = srd_pkg::IN_W'(-16384);
    localparam logic signed [srd_pkg::IN_W-1:0] IN_MAX = srd_pkg::IN_W'(16383);

    typedef struct packed {
        logic signed [srd_pkg::IN_W-1:0] x;
        logic signed [srd_pkg::IN_W-1:0] y;
    } sample_t;

    typedef struct packed {
        logic signed [srd_pkg::OUT_W-1:0] x;
        logic signed [srd_pkg::OUT_W-1:0] y;
        logic                             dead;
        logic                             err;
    } stick_res_t;

    logic clk, rst_n, done, in_dead_zone, config_error, busy;
    logic start = 1'b0;
    logic signed [srd_pkg::IN_W-1:0] x_in = '0;
    logic signed [srd_pkg::IN_W-1:0] y_in = '0;
    logic signed [srd_pkg::OUT_W-1:0] x_out, y_out;
    logic cfg_we;
    logic [srd_pkg::CFG_A_W-1:0] cfg_addr;
    logic [srd_pkg::CFG_W-1:0] cfg_wdata;

    stick_radial_deadzone dut (.*);

    sample_t pending[$];
    stick_res_t expected[$];
    longint unsigned dz_reg, max_reg;
    int errors = 0;
    longint cycles = 0;
    bit hold_off, quiet;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [srd_pkg::OUT_W-1:0] scale_axis(longint a, longint unsigned live,
                                                             longint unsigned den);
        longint unsigned mag, num, q;
        mag = (a < 0) ? -a : a;
        num = mag * max_reg * live;
        q = (2 * num + den) / (2 * den);
        if (a < 0)
            return (q > 32768) ? 16'sh8000 : srd_pkg::OUT_W'(-longint'(q));
        return (q > 32767) ? 16'sh7fff : srd_pkg::OUT_W'(q);
    endfunction

    function automatic stick_res_t predict_stick(sample_t smp);
        stick_res_t r;
        longint x, y;
        longint unsigned s, m, dzg, live, den;
        r = '0;
        x = smp.x;
        y = smp.y;
        if (max_reg <= dz_reg)
        begin
            r.err = 1'b1;
            return r;
        end
        s = x * x + y * y;
        if (s < dz_reg * dz_reg)
        begin
            r.dead = 1'b1;
            return r;
        end
        m = int_sqrt(s << (2 * srd_pkg::GUARD));
        if (m == 0) return r;
        dzg = dz_reg << srd_pkg::GUARD;
        live = (m >= dzg) ? m - dzg : 0;
        den = m * (max_reg - dz_reg);
        r.x = scale_axis(x, live, den);
        r.y = scale_axis(y, live, den);
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_stick_radial_deadzone: done, errors");
            $finish;
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected.push_back(predict_stick({x_in, y_in}));
            if ((!start || !busy) && pending.size() > 0 && !hold_off
                && (quiet || $urandom_range(99) >= 11))
            begin
                sample_t smp;
                smp = pending.pop_front();
                start <= 1'b1;
                x_in <= smp.x;
                y_in <= smp.y;
            end
            else if (!start || !busy)
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            stick_res_t got, want;
            got = {x_out, y_out, in_dead_zone, config_error};
            if (expected.size() == 0)
            begin
                $display("%0t: unexpected transaction %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected x=%0d y=%0d dz=%b err=%b",
                        $time, want.x, want.y, want.dead, want.err,
                        " actual x=%0d y=%0d dz=%b err=%b",
                        got.x, got.y, got.dead, got.err);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (pending.size() > 0 || start || expected.size() > 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [srd_pkg::CFG_A_W-1:0] idx, longint unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= srd_pkg::CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == srd_pkg::CFG_DEAD_ZONE) dz_reg = val & 16'h3fff;
        else max_reg = val & 16'h7fff;
    endtask

    function automatic sample_t rand_sample();
        sample_t s;
        case ($urandom_range(3))
            0:
            begin
                s.x = srd_pkg::IN_W'($urandom);
                s.y = srd_pkg::IN_W'($urandom);
            end
            1:
            begin
                s.x = srd_pkg::IN_W'(int'($urandom_range(4000)) - 2000);
                s.y = srd_pkg::IN_W'(int'($urandom_range(4000)) - 2000);
            end
            2:
            begin
                s.x = $urandom_range(1) ? IN_MIN : IN_MAX;
                s.y = srd_pkg::IN_W'($urandom);
            end
            default:
            begin
                s.x = srd_pkg::IN_W'(int'($urandom_range(600)) - 300);
                s.y = srd_pkg::IN_W'(int'($urandom_range(600)) - 300);
            end
        endcase
        return s;
    endfunction

    initial
    begin
        int phase;
        hold_off = 1;
        quiet = 0;
        cfg_we = 0;
        cfg_addr = '0;
        cfg_wdata = '0;
        dz_reg = 1638;
        max_reg = 13107;
        rst_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        pending.push_back('{15'sd0, 15'sd0});
        pending.push_back('{IN_MAX, IN_MAX});
        pending.push_back('{IN_MIN, IN_MIN});
        pending.push_back('{IN_MAX, IN_MIN});
        pending.push_back('{15'sd1000, 15'sd0});
        pending.push_back('{15'sd1638, 15'sd0});
        pending.push_back('{15'sd1637, 15'sd0});
        pending.push_back('{15'sd0, -15'sd5000});
        pending.push_back('{15'sd13107, 15'sd0});
        pending.push_back('{-15'sd1, 15'sd1});
        hold_off = 0;
        drain();
        write_reg(srd_pkg::CFG_DEAD_ZONE, 0);
        write_reg(srd_pkg::CFG_MAX_LEVEL, 1);
        pending.push_back('{15'sd0, 15'sd0});
        pending.push_back('{15'sd1, 15'sd0});
        pending.push_back('{IN_MIN, IN_MAX});
        drain();
        write_reg(srd_pkg::CFG_DEAD_ZONE, 16383);
        write_reg(srd_pkg::CFG_MAX_LEVEL, 16384);
        pending.push_back('{IN_MIN, 15'sd0});
        pending.push_back('{IN_MAX, IN_MAX});
        pending.push_back('{15'sd100, 15'sd0});
        drain();
        write_reg(srd_pkg::CFG_MAX_LEVEL, 16383);
        pending.push_back('{15'sd5, 15'sd5});
        drain();
        for (phase = 0; phase < 6; phase++)
        begin
            longint unsigned d, mx;
            d = (phase == 5) ? 0 : longint'($urandom_range(16383 >> (phase % 3 * 3)));
            mx = (phase == 4) ? d
                : longint'($urandom_range(16384, 32'((d >= 16384) ? 16384 : d + 1)));
            write_reg(srd_pkg::CFG_DEAD_ZONE, d);
            write_reg(srd_pkg::CFG_MAX_LEVEL, mx);
            quiet = (phase == 2);
            repeat (70) pending.push_back(rand_sample());
            drain();
        end
        write_reg(srd_pkg::CFG_DEAD_ZONE, 1638);
        write_reg(srd_pkg::CFG_MAX_LEVEL, 13107);
        if (errors == 0)
            $display("tb_stick_radial_deadzone: done, clean");
        else
            $display("tb_stick_radial_deadzone: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/srd_pkg.sv
sv/srd_front.sv
sv/srd_fifo.sv
sv/srd_back.sv
sv/stick_radial_deadzone.sv
tb/tb_stick_radial_deadzone.sv
